// ===== hdl/brm_pkg.sv =====
// Shared types and constants for the banked ROM mapper.
// No dependencies; used by every module of the block.
package brm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_CPU_LOOK = 2'd2,
    CMD_PPU_LOOK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_PAT_ROM = 3'd3,
    TGT_NT_RAM  = 3'd4
  } tgt_t;

  typedef enum logic [1:0] {
    MIR_HORZ    = 2'd0,
    MIR_VERT    = 2'd1,
    MIR_SINGLE0 = 2'd2,
    MIR_SINGLE1 = 2'd3
  } mir_t;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int MADDR_W = 21;
  localparam int BANK_W  = 8;

  localparam logic [BANK_W-1:0] PRG_FIXED_BANK = 8'hFF;
  localparam logic [BANK_W-1:0] PRG0_RST       = 8'h00;
  localparam logic [BANK_W-1:0] PRG1_RST       = 8'h01;
  localparam logic [BANK_W-1:0] PRG2_RST       = 8'hFE;

  // Bank and mirroring state seen by the address translator
  typedef struct packed {
    logic [2:0][BANK_W-1:0] prog_bank;
    logic [7:0][BANK_W-1:0] pat_bank;
    mir_t                   mirror;
  } map_state_t;

endpackage

// ===== hdl/brm_regs.sv =====
// Mapper register file and IRQ down-counter; updated once per request.
// Depends on brm_pkg.
module brm_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  brm_pkg::cmd_t             cmd,
  input  logic [brm_pkg::ADDR_W-1:0] addr,
  input  logic [brm_pkg::DATA_W-1:0] wdata,
  output brm_pkg::map_state_t       map_state,
  output logic                      irq_line_nxt,
  output logic                      sram_off_nxt
);

  localparam logic [2:0] GRP_PRG01 = 3'd0;
  localparam logic [2:0] GRP_PRG2  = 3'd1;
  localparam logic [2:0] GRP_PAT01 = 3'd2;
  localparam logic [2:0] GRP_PAT23 = 3'd3;
  localparam logic [2:0] GRP_PAT45 = 3'd4;
  localparam logic [2:0] GRP_PAT67 = 3'd5;
  localparam logic [2:0] GRP_RELOAD = 3'd6;
  localparam logic [2:0] GRP_CTRL  = 3'd7;

  localparam logic [1:0] CTRL_RELOAD = 2'd0;
  localparam logic [1:0] CTRL_MODE   = 2'd1;
  localparam logic [1:0] CTRL_MIRROR = 2'd2;
  localparam logic [1:0] SEL_SRAM    = 2'd2;

  logic [2:0][7:0] prog_bank_r, prog_bank_nxt;
  logic [7:0][7:0] pat_bank_r, pat_bank_nxt;
  logic [15:0]     irq_count_r, irq_count_nxt;
  logic [15:0]     irq_reload_r, irq_reload_nxt;
  logic [3:0]      irq_mode_r, irq_mode_nxt;
  brm_pkg::mir_t   mirror_r, mirror_nxt;
  logic            sram_off_r;
  logic            irq_line_r;

  logic [2:0]  grp;
  logic [1:0]  sel;
  logic [3:0]  nib;
  logic [2:0]  pat_idx;
  logic        wr;
  logic        tick;
  logic [15:0] cnt_mask;

  function automatic logic [7:0] set_nib(input logic [7:0] r, input logic hi,
                                         input logic [3:0] v);
    set_nib = hi ? {v, r[3:0]} : {r[7:4], v};
  endfunction

  assign grp     = addr[14:12];
  assign sel     = addr[1:0];
  assign nib     = wdata[3:0];
  assign pat_idx = {grp[1:0] - 2'd2, sel[1]};
  assign wr      = fire && (cmd == brm_pkg::CMD_WRITE) && addr[15];
  assign tick    = fire && (cmd == brm_pkg::CMD_TICK) && irq_mode_r[0];

  // narrowest selected counter width wins
  always_comb begin
    if (irq_mode_r[3]) begin
      cnt_mask = 16'h000F;
    end else if (irq_mode_r[2]) begin
      cnt_mask = 16'h00FF;
    end else if (irq_mode_r[1]) begin
      cnt_mask = 16'h0FFF;
    end else begin
      cnt_mask = 16'hFFFF;
    end
  end

  always_comb begin
    prog_bank_nxt  = prog_bank_r;
    pat_bank_nxt   = pat_bank_r;
    irq_count_nxt  = irq_count_r;
    irq_reload_nxt = irq_reload_r;
    irq_mode_nxt   = irq_mode_r;
    mirror_nxt     = mirror_r;
    sram_off_nxt   = sram_off_r;
    irq_line_nxt   = irq_line_r;
    if (wr) begin
      case (grp)
        GRP_PRG01: begin
          prog_bank_nxt[{1'b0, sel[1]}] = set_nib(prog_bank_r[{1'b0, sel[1]}], sel[0], nib);
        end
        GRP_PRG2: begin
          if (!sel[1]) begin
            prog_bank_nxt[2] = set_nib(prog_bank_r[2], sel[0], nib);
          end else if (sel == SEL_SRAM) begin
            sram_off_nxt = wdata[0];
          end
        end
        GRP_PAT01, GRP_PAT23, GRP_PAT45, GRP_PAT67: begin
          pat_bank_nxt[pat_idx] = set_nib(pat_bank_r[pat_idx], sel[0], nib);
        end
        GRP_RELOAD: begin
          irq_reload_nxt[sel*4 +: 4] = nib;
        end
        GRP_CTRL: begin
          case (sel)
            CTRL_RELOAD: begin
              irq_count_nxt = irq_reload_r;
              irq_line_nxt  = 1'b0;
            end
            CTRL_MODE: begin
              irq_mode_nxt = nib;
              irq_line_nxt = 1'b0;
            end
            CTRL_MIRROR: begin
              mirror_nxt = brm_pkg::mir_t'(wdata[1:0]);
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end else if (tick) begin
      // test before the decrement
      if ((irq_count_r & cnt_mask) == 16'd0) begin
        irq_line_nxt = 1'b1;
      end
      irq_count_nxt = irq_count_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_bank_r  <= {brm_pkg::PRG2_RST, brm_pkg::PRG1_RST, brm_pkg::PRG0_RST};
      for (int i = 0; i < 8; i++) begin
        pat_bank_r[i] <= 8'(i);
      end
      irq_count_r  <= '0;
      irq_reload_r <= '0;
      irq_mode_r   <= '0;
      mirror_r     <= brm_pkg::MIR_HORZ;
      sram_off_r   <= 1'b1;
      irq_line_r   <= 1'b0;
    end else begin
      prog_bank_r  <= prog_bank_nxt;
      pat_bank_r   <= pat_bank_nxt;
      irq_count_r  <= irq_count_nxt;
      irq_reload_r <= irq_reload_nxt;
      irq_mode_r   <= irq_mode_nxt;
      mirror_r     <= mirror_nxt;
      sram_off_r   <= sram_off_nxt;
      irq_line_r   <= irq_line_nxt;
    end
  end

  assign map_state.prog_bank = prog_bank_r;
  assign map_state.pat_bank  = pat_bank_r;
  assign map_state.mirror    = mirror_r;

endmodule

// ===== hdl/brm_xlat.sv =====
// CPU and PPU address translation from the current bank state.
// Combinational; depends on brm_pkg.
module brm_xlat (
  input  brm_pkg::cmd_t               cmd,
  input  logic [brm_pkg::ADDR_W-1:0]  addr,
  input  brm_pkg::map_state_t         map_state,
  output logic [brm_pkg::MADDR_W-1:0] maddr,
  output brm_pkg::tgt_t               tgt
);

  logic [7:0] prg_bank;
  logic [7:0] pat_bank;
  logic       page;

  always_comb begin
    prg_bank = (addr[14:13] == 2'b11) ? brm_pkg::PRG_FIXED_BANK
                                      : map_state.prog_bank[addr[14:13]];
    pat_bank = map_state.pat_bank[addr[12:10]];
    case (map_state.mirror)
      brm_pkg::MIR_HORZ:    page = addr[11];
      brm_pkg::MIR_VERT:    page = addr[10];
      brm_pkg::MIR_SINGLE0: page = 1'b0;
      brm_pkg::MIR_SINGLE1: page = 1'b1;
      default:              page = 1'b0;
    endcase
  end

  always_comb begin
    maddr = '0;
    tgt   = brm_pkg::TGT_NONE;
    case (cmd)
      brm_pkg::CMD_CPU_LOOK: begin
        if (addr[15]) begin
          maddr = {prg_bank, addr[12:0]};
          tgt   = brm_pkg::TGT_PRG_ROM;
        end else if (addr[14:13] == 2'b11) begin
          maddr = {8'd0, addr[12:0]};
          tgt   = brm_pkg::TGT_PRG_RAM;
        end
      end
      brm_pkg::CMD_PPU_LOOK: begin
        if (!addr[13]) begin
          maddr = {3'd0, pat_bank, addr[9:0]};
          tgt   = brm_pkg::TGT_PAT_ROM;
        end else begin
          // palette range maps like the nametables
          maddr = {10'd0, page, addr[9:0]};
          tgt   = brm_pkg::TGT_NT_RAM;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/banked_rom_mapper_with_irq_counter.sv =====
// Top level of the banked ROM mapper with IRQ counter.
// Depends on brm_pkg, brm_regs and brm_xlat.
//
//   channel  | ports                                       | direction
//   ---------+---------------------------------------------+----------
//   request  | in_valid/in_ready, in_cmd, in_addr, in_wdata | in
//   result   | out_valid/out_ready, out_mapped_addr,       | out
//            | out_target, out_irq_asserted, out_sram_disabled
//
// One request per clock sustained while the result is not stalled; a result
// passes through the input register, then the result register.
// Register updates and translation happen as a request leaves the input
// register, so requests see state strictly in order.
// rst_n (synchronous) restores the bank, IRQ and mirroring defaults.
// A stalled result holds the result register; the input register still
// takes one more request, after which in_ready drops.
module banked_rom_mapper_with_irq_counter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic [brm_pkg::ADDR_W-1:0]          in_addr,
  input  logic [brm_pkg::DATA_W-1:0]          in_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [brm_pkg::MADDR_W-1:0]         out_mapped_addr,
  output logic [2:0]                          out_target,
  output logic                                out_irq_asserted,
  output logic                                out_sram_disabled
);

  logic                         s1_valid_r;
  brm_pkg::cmd_t                s1_cmd_r;
  logic [brm_pkg::ADDR_W-1:0]   s1_addr_r;
  logic [brm_pkg::DATA_W-1:0]   s1_wdata_r;

  logic                         out_valid_r;
  logic [brm_pkg::MADDR_W-1:0]  out_maddr_r;
  brm_pkg::tgt_t                out_tgt_r;
  logic                         out_irq_r;
  logic                         out_sram_r;

  logic                         fire;
  logic                         in_fire;
  brm_pkg::map_state_t          map_state;
  logic                         irq_line_nxt;
  logic                         sram_off_nxt;
  logic [brm_pkg::MADDR_W-1:0]  maddr;
  brm_pkg::tgt_t                tgt;

  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;
  assign in_fire  = in_valid && in_ready;

  brm_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .cmd          (s1_cmd_r),
    .addr         (s1_addr_r),
    .wdata        (s1_wdata_r),
    .map_state    (map_state),
    .irq_line_nxt (irq_line_nxt),
    .sram_off_nxt (sram_off_nxt)
  );

  brm_xlat u_xlat (
    .cmd       (s1_cmd_r),
    .addr      (s1_addr_r),
    .map_state (map_state),
    .maddr     (maddr),
    .tgt       (tgt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= brm_pkg::cmd_t'(in_cmd);
      s1_addr_r  <= in_addr;
      s1_wdata_r <= in_wdata;
    end
    if (fire) begin
      out_maddr_r <= maddr;
      out_tgt_r   <= tgt;
      out_irq_r   <= irq_line_nxt;
      out_sram_r  <= sram_off_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mapped_addr   = out_maddr_r;
  assign out_target        = out_tgt_r;
  assign out_irq_asserted  = out_irq_r;
  assign out_sram_disabled = out_sram_r;

endmodule

// ===== hdl/brm_checker.sv =====
// Port-level checks for the banked ROM mapper, bound to the top level.
// Depends on brm_pkg and banked_rom_mapper_with_irq_counter.
module brm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [brm_pkg::MADDR_W-1:0]         out_mapped_addr,
  input logic [2:0]                          out_target,
  input logic                                out_irq_asserted,
  input logic                                out_sram_disabled
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mapped_addr) &&
      $stable(out_target) && $stable(out_irq_asserted) && $stable(out_sram_disabled))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_target == brm_pkg::TGT_NONE) |-> out_mapped_addr == '0)
    else $error("write, tick or unmapped request returned an offset");

  a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_target == brm_pkg::TGT_NONE) || (out_target == brm_pkg::TGT_PRG_ROM) ||
      (out_target == brm_pkg::TGT_PRG_RAM) || (out_target == brm_pkg::TGT_PAT_ROM) ||
      (out_target == brm_pkg::TGT_NT_RAM))
    else $error("target code out of range");

  a_small_windows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_target != brm_pkg::TGT_PRG_RAM) || (out_mapped_addr[20:13] == '0)) &&
      ((out_target != brm_pkg::TGT_PAT_ROM) || (out_mapped_addr[20:18] == '0)) &&
      ((out_target != brm_pkg::TGT_NT_RAM)  || (out_mapped_addr[20:11] == '0)))
    else $error("offset exceeds target window");

endmodule

bind banked_rom_mapper_with_irq_counter brm_checker u_brm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_mapped_addr   (out_mapped_addr),
  .out_target        (out_target),
  .out_irq_asserted  (out_irq_asserted),
  .out_sram_disabled (out_sram_disabled)
);

// ===== verif/banked_rom_mapper_with_irq_counter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for banked_rom_mapper_with_irq_counter.
// Depends on brm_pkg and the mapper RTL; keeps its own model of the bank,
// IRQ and mirroring registers and checks every result in order.
module banked_rom_mapper_with_irq_counter_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 750;

  // write map: address bits 14:12 pick the group, bits 1:0 the field
  localparam logic [2:0] GRP_PRG01     = 3'd0;
  localparam logic [2:0] GRP_PRG2      = 3'd1;
  localparam logic [2:0] GRP_PAT_FIRST = 3'd2;
  localparam logic [2:0] GRP_IRQ_RLD   = 3'd6;
  localparam logic [2:0] GRP_IRQ_CTL   = 3'd7;
  localparam logic [1:0] SEL_SRAM      = 2'd2;
  localparam logic [1:0] CTL_RELOAD    = 2'd0;
  localparam logic [1:0] CTL_MODE      = 2'd1;
  localparam logic [1:0] CTL_MIRROR    = 2'd2;
  localparam logic [1:0] CTL_NOP       = 2'd3;

  typedef struct {
    brm_pkg::cmd_t              cmd;
    logic [brm_pkg::ADDR_W-1:0] addr;
    logic [brm_pkg::DATA_W-1:0] wdata;
  } bus_req_t;

  typedef struct {
    logic [brm_pkg::MADDR_W-1:0] mapped_addr;
    brm_pkg::tgt_t               target;
    logic                        irq;
    logic                        sram_dis;
  } bus_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   in_cmd = 2'd0;
  logic [brm_pkg::ADDR_W-1:0]   in_addr = '0;
  logic [brm_pkg::DATA_W-1:0]   in_wdata = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [brm_pkg::MADDR_W-1:0]  out_mapped_addr;
  logic [2:0]                   out_target;
  logic                         out_irq_asserted;
  logic                         out_sram_disabled;

  banked_rom_mapper_with_irq_counter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_addr(in_addr),
    .in_wdata(in_wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mapped_addr(out_mapped_addr),
    .out_target(out_target),
    .out_irq_asserted(out_irq_asserted),
    .out_sram_disabled(out_sram_disabled)
  );

  always #10 clk = ~clk;

  // mapper state as the model sees it
  logic [7:0]     prg_bank [3];
  logic [7:0]     pat_bank [8];
  logic [15:0]    irq_cnt;
  logic [15:0]    irq_rld;
  logic [3:0]     irq_ctl;
  brm_pkg::mir_t  mirror;
  logic           sram_off;
  logic           irq_line;

  bus_req_t    req_queue [$];
  bus_result_t expected_results [$];

  int          stim_count = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          irq_results = 0;
  int          cmd_seen [4] = '{0, 0, 0, 0};
  logic [31:0] cyc = '0;

  function automatic logic [15:0] reg_addr(input logic [2:0] grp, input logic [1:0] sel);
    return {1'b1, grp, 10'd0, sel};
  endfunction

  function automatic logic [15:0] count_window();
    if (irq_ctl[3]) return 16'h000F;
    if (irq_ctl[2]) return 16'h00FF;
    if (irq_ctl[1]) return 16'h0FFF;
    return 16'hFFFF;
  endfunction

  task automatic reset_mapper_model();
    prg_bank[0] = brm_pkg::PRG0_RST;
    prg_bank[1] = brm_pkg::PRG1_RST;
    prg_bank[2] = brm_pkg::PRG2_RST;
    for (int i = 0; i < 8; i++) pat_bank[i] = 8'(i);
    irq_cnt  = '0;
    irq_rld  = '0;
    irq_ctl  = '0;
    mirror   = brm_pkg::MIR_HORZ;
    sram_off = 1'b1;
    irq_line = 1'b0;
  endtask

  task automatic apply_register_write(input logic [15:0] a, input logic [7:0] v);
    logic [2:0] grp;
    logic [1:0] sel;
    logic [3:0] nib;
    logic [2:0] pat_off;
    logic [2:0] idx;
    grp = a[14:12];
    sel = a[1:0];
    nib = v[3:0];
    if (!a[15]) return;
    case (grp)
      GRP_PRG01: begin
        if (sel[0]) prg_bank[sel[1]][7:4] = nib;
        else prg_bank[sel[1]][3:0] = nib;
      end
      GRP_PRG2: begin
        if (!sel[1]) begin
          if (sel[0]) prg_bank[2][7:4] = nib;
          else prg_bank[2][3:0] = nib;
        end else if (sel == SEL_SRAM) begin
          sram_off = v[0];
        end
      end
      GRP_IRQ_RLD: irq_rld[sel*4 +: 4] = nib;
      GRP_IRQ_CTL: begin
        case (sel)
          CTL_RELOAD: begin
            irq_cnt  = irq_rld;
            irq_line = 1'b0;
          end
          CTL_MODE: begin
            irq_ctl  = nib;
            irq_line = 1'b0;
          end
          CTL_MIRROR: mirror = brm_pkg::mir_t'(v[1:0]);
          default: ;
        endcase
      end
      default: begin
        pat_off = grp - GRP_PAT_FIRST;
        idx = {pat_off[1:0], sel[1]};
        if (sel[0]) pat_bank[idx][7:4] = nib;
        else pat_bank[idx][3:0] = nib;
      end
    endcase
  endtask

  // Update the model with one accepted request and queue the result it must give
  task automatic apply_bus_request(input bus_req_t r);
    bus_result_t res;
    logic [7:0]  bank;
    logic        page;
    res.mapped_addr = '0;
    res.target = brm_pkg::TGT_NONE;
    case (r.cmd)
      brm_pkg::CMD_WRITE: apply_register_write(r.addr, r.wdata);
      brm_pkg::CMD_TICK: begin
        if (irq_ctl[0]) begin
          if ((irq_cnt & count_window()) == 16'h0000) irq_line = 1'b1;
          irq_cnt = irq_cnt - 16'd1;
        end
      end
      brm_pkg::CMD_CPU_LOOK: begin
        if (r.addr[15]) begin
          bank = (r.addr[14:13] == 2'b11) ? brm_pkg::PRG_FIXED_BANK
                                          : prg_bank[r.addr[14:13]];
          res.mapped_addr = {bank, r.addr[12:0]};
          res.target = brm_pkg::TGT_PRG_ROM;
        end else if (r.addr[14:13] == 2'b11) begin
          res.mapped_addr = {8'd0, r.addr[12:0]};
          res.target = brm_pkg::TGT_PRG_RAM;
        end
      end
      default: begin
        if (!r.addr[13]) begin
          res.mapped_addr = {3'd0, pat_bank[r.addr[12:10]], r.addr[9:0]};
          res.target = brm_pkg::TGT_PAT_ROM;
        end else begin
          case (mirror)
            brm_pkg::MIR_HORZ:    page = r.addr[11];
            brm_pkg::MIR_VERT:    page = r.addr[10];
            brm_pkg::MIR_SINGLE0: page = 1'b0;
            default:              page = 1'b1;
          endcase
          res.mapped_addr = {10'd0, page, r.addr[9:0]};
          res.target = brm_pkg::TGT_NT_RAM;
        end
      end
    endcase
    res.irq = irq_line;
    res.sram_dis = sram_off;
    expected_results.push_back(res);
  endtask

  task automatic push_req(input brm_pkg::cmd_t c, input logic [15:0] a,
                          input logic [7:0] v);
    bus_req_t r;
    r.cmd = c;
    r.addr = a;
    r.wdata = v;
    req_queue.push_back(r);
    // writes below the register window change nothing
    if (!(c == brm_pkg::CMD_WRITE && !a[15])) stim_count++;
  endtask

  task automatic push_random_req();
    brm_pkg::cmd_t c;
    logic [15:0]   a;
    c = brm_pkg::cmd_t'($urandom_range(0, 3));
    a = 16'($urandom);
    if (c == brm_pkg::CMD_WRITE && $urandom_range(0, 9) != 0) a[15] = 1'b1;
    push_req(c, a, 8'($urandom));
  endtask

  // Load a short reload value, restart the counter and tick it toward an IRQ
  task automatic push_irq_run();
    logic [3:0] nib;
    for (int n = 0; n < 4; n++) begin
      nib = 4'($urandom);
      if (n > 0 && $urandom_range(0, 1) == 0) nib = 4'd0;
      push_req(brm_pkg::CMD_WRITE,
               reg_addr(GRP_IRQ_RLD, 2'(n)) | 16'($urandom_range(0, 3) << 2),
               {4'($urandom), nib});
    end
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_IRQ_CTL, CTL_RELOAD), 8'($urandom));
    nib = 4'($urandom);
    if ($urandom_range(0, 4) != 0) nib[0] = 1'b1;
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_IRQ_CTL, CTL_MODE), {4'($urandom), nib});
    repeat ($urandom_range(4, 40)) begin
      if ($urandom_range(0, 7) == 0) push_random_req();
      else push_req(brm_pkg::CMD_TICK, 16'($urandom), 8'($urandom));
    end
  endtask

  // Request driver: bursts of random length separated by random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    bus_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        apply_bus_request('{brm_pkg::cmd_t'(in_cmd), in_addr, in_wdata});
        cmd_seen[in_cmd]++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        nxt = req_queue.pop_front();
        in_cmd   <= nxt.cmd;
        in_addr  <= nxt.addr;
        in_wdata <= nxt.wdata;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor; the receiver picks a new stall pattern whenever cyc[6:0] is zero
  logic [1:0] stall_mode = 2'd0;

  always @(posedge clk) begin
    bus_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_irq_asserted === 1'b1) irq_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0d] result with no request pending: addr=%h tgt=%0d irq=%b sram=%b",
                     cyc, out_mapped_addr, out_target, out_irq_asserted, out_sram_disabled);
        end else begin
          e = expected_results.pop_front();
          if (out_mapped_addr !== e.mapped_addr || out_target !== e.target ||
              out_irq_asserted !== e.irq || out_sram_disabled !== e.sram_dis) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"[%0d] mismatch: exp addr=%h tgt=%0d irq=%b sram=%b,",
                        " got addr=%h tgt=%0d irq=%b sram=%b"},
                       cyc, e.mapped_addr, e.target, e.irq, e.sram_dis,
                       out_mapped_addr, out_target, out_irq_asserted, out_sram_disabled);
          end
        end
      end
      if (cyc[6:0] == 7'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= cyc[0];
        2'd2:    out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (cyc[3:0] >= 4'd10);
      endcase
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc,
               expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    reset_mapper_model();

    // address windows at reset state
    push_req(brm_pkg::CMD_CPU_LOOK, 16'h0000, 8'h00);
    push_req(brm_pkg::CMD_CPU_LOOK, 16'h5FFF, 8'hFF);
    push_req(brm_pkg::CMD_CPU_LOOK, 16'h6000, 8'h00);
    push_req(brm_pkg::CMD_CPU_LOOK, 16'h7FFF, 8'h00);
    push_req(brm_pkg::CMD_CPU_LOOK, 16'h8000, 8'h00);
    push_req(brm_pkg::CMD_CPU_LOOK, 16'hDFFF, 8'h00);
    push_req(brm_pkg::CMD_CPU_LOOK, 16'hFFFF, 8'h00);
    push_req(brm_pkg::CMD_PPU_LOOK, 16'hC000, 8'h00);
    push_req(brm_pkg::CMD_PPU_LOOK, 16'h1FFF, 8'h00);
    push_req(brm_pkg::CMD_PPU_LOOK, 16'h3FFF, 8'h00);
    // write below the register window is dropped
    push_req(brm_pkg::CMD_WRITE, 16'h7FFF, 8'hFF);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_PRG01, 2'd0), 8'hFF);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_PRG01, 2'd1), 8'hFF);
    push_req(brm_pkg::CMD_CPU_LOOK, 16'h9FFF, 8'h00);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_PRG2, SEL_SRAM), 8'hFE);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_PRG2, 2'd3), 8'hFF);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_IRQ_CTL, CTL_MIRROR), 8'hFD);
    push_req(brm_pkg::CMD_PPU_LOOK, 16'h2400, 8'h00);
    // counter from 2 with full mask: IRQ on the third tick, then a mode write clears it
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_IRQ_RLD, 2'd0), 8'hF2);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_IRQ_CTL, CTL_RELOAD), 8'h00);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_IRQ_CTL, CTL_MODE), 8'hF1);
    repeat (4) push_req(brm_pkg::CMD_TICK, 16'h0000, 8'h00);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_IRQ_CTL, CTL_MODE), 8'h09);
    push_req(brm_pkg::CMD_WRITE, reg_addr(GRP_IRQ_CTL, CTL_NOP), 8'hFF);

    stim_count = 0;
    while (stim_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) push_irq_run();
      else repeat ($urandom_range(1, 8)) push_random_req();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests taken: %0d writes, %0d ticks, %0d cpu lookups, %0d ppu lookups",
             cmd_seen[brm_pkg::CMD_WRITE], cmd_seen[brm_pkg::CMD_TICK],
             cmd_seen[brm_pkg::CMD_CPU_LOOK], cmd_seen[brm_pkg::CMD_PPU_LOOK]);
    $display("%0d results checked, %0d with IRQ raised, %0d mismatches",
             results_seen, irq_results, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
